// ----- rtl/wfmd_pkg.sv -----
// Package for the windowed fault monitor: request and result types, function codes, edge masks.
`default_nettype none

package wfmd_pkg;

  localparam int CHAN_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int TIME_W   = 16;
  localparam int WORD_W   = 32;

  typedef logic [2:0] func_t;

  localparam func_t FUNC_POLL      = 3'd0;
  localparam func_t FUNC_TRIP      = 3'd1;
  localparam func_t FUNC_CLR_ALL   = 3'd2;
  localparam func_t FUNC_CLR_HIST  = 3'd3;
  localparam func_t FUNC_CONFIG    = 3'd4;

  localparam logic [1:0] EDGE_UPPER = 2'h1;
  localparam logic [1:0] EDGE_LOWER = 2'h2;

  typedef struct packed {
    func_t                      func;
    logic [CHAN_W-1:0]          channel;
    logic signed [VALUE_W-1:0]  sample;
    logic signed [VALUE_W-1:0]  upper_bound;
    logic signed [VALUE_W-1:0]  lower_bound;
    logic [1:0]                 edge_enable;
    logic [TIME_W-1:0]          detect_time;
    logic [TIME_W-1:0]          recover_time;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] active_faults;
    logic [WORD_W-1:0] fault_history;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/windowed_fault_monitor_debounce.sv -----
// A poll that runs its debounce count goes through dispatch, the high and low compares,
// the count steps and finish; an in-range poll on a clear channel skips the count steps;
// a poll on an unregistered channel and any other request go from dispatch to finish. The
// next request is taken in the cycle after the result is loaded. A poll makes up to four
// passes through the one shared 32-bit signed comparator. A held result stalls the input.
// Reset (synchronous, rst_n low) clears both fault words, all counters and all enables.
`default_nettype none

module windowed_fault_monitor_debounce #(
  parameter int NUM_CHANNELS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wfmd_pkg::item_t         in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output wfmd_pkg::result_t       out_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CMP_HI,
    ST_CMP_LO,
    ST_CNT_LT,
    ST_CNT_GE,
    ST_FINISH
  } state_t;

  state_t                             state_r;
  wfmd_pkg::item_t                    item_r;
  logic [wfmd_pkg::WORD_W-1:0]        active_r;
  logic [wfmd_pkg::WORD_W-1:0]        history_r;
  logic                               out_valid_r;
  wfmd_pkg::result_t                  out_data_r;

  // Channel table.
  logic [1:0]                         en_r     [NUM_CHANNELS];
  logic signed [wfmd_pkg::VALUE_W-1:0] upper_r [NUM_CHANNELS];
  logic signed [wfmd_pkg::VALUE_W-1:0] lower_r [NUM_CHANNELS];
  logic [wfmd_pkg::TIME_W-1:0]        det_r    [NUM_CHANNELS];
  logic [wfmd_pkg::TIME_W-1:0]        rec_r    [NUM_CHANNELS];
  logic [wfmd_pkg::TIME_W-1:0]        vcnt_r   [NUM_CHANNELS];
  logic [wfmd_pkg::TIME_W-1:0]        rcnt_r   [NUM_CHANNELS];

  // Working copy of the polled channel.
  logic [1:0]                         wen_r;
  logic signed [wfmd_pkg::VALUE_W-1:0] wupper_r;
  logic signed [wfmd_pkg::VALUE_W-1:0] wlower_r;
  logic                               viol_r;
  logic [wfmd_pkg::TIME_W-1:0]        cnt_r;
  logic [wfmd_pkg::TIME_W-1:0]        lim_r;

  logic [IDX_W-1:0]                   idx;
  logic                               ch_ok;
  logic [wfmd_pkg::WORD_W-1:0]        ch_bit;
  logic                               in_acc;
  logic                               viol_nxt;

  // Shared comparator.
  logic signed [wfmd_pkg::VALUE_W-1:0] cmp_a;
  logic signed [wfmd_pkg::VALUE_W-1:0] cmp_b;
  logic                               cmp_gt;

  assign idx      = item_r.channel[IDX_W-1:0];
  assign ch_ok    = {27'd0, item_r.channel} < NUM_CHANNELS;
  assign ch_bit   = {{(wfmd_pkg::WORD_W-1){1'b0}}, 1'b1} << item_r.channel;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cmp_a = item_r.sample;
    cmp_b = wupper_r;
    case (state_r)
      ST_CMP_HI: begin
        cmp_a = item_r.sample;
        cmp_b = wupper_r;
      end
      ST_CMP_LO: begin
        cmp_a = wlower_r;
        cmp_b = item_r.sample;
      end
      ST_CNT_LT, ST_CNT_GE: begin
        cmp_a = $signed({16'd0, lim_r});
        cmp_b = $signed({16'd0, cnt_r});
      end
      default: begin
        cmp_a = item_r.sample;
        cmp_b = wupper_r;
      end
    endcase
  end

  assign cmp_gt   = cmp_a > cmp_b;
  assign viol_nxt = viol_r || ((wen_r & wfmd_pkg::EDGE_LOWER) != 2'd0 && cmp_gt);

  // Settings written only by configure; they need no reset because enables gate their use.
  always_ff @(posedge clk) begin
    if (state_r == ST_DISPATCH && item_r.func == wfmd_pkg::FUNC_CONFIG && ch_ok) begin
      upper_r[idx] <= item_r.upper_bound;
      lower_r[idx] <= item_r.lower_bound;
      det_r[idx]   <= item_r.detect_time;
      rec_r[idx]   <= item_r.recover_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      history_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        en_r[i]   <= 2'd0;
        vcnt_r[i] <= '0;
        rcnt_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            item_r  <= in_data;
            state_r <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          case (item_r.func)
            wfmd_pkg::FUNC_POLL: begin
              wen_r    <= en_r[idx];
              wupper_r <= upper_r[idx];
              wlower_r <= lower_r[idx];
              if (ch_ok && en_r[idx] != 2'd0) begin
                state_r <= ST_CMP_HI;
              end else begin
                state_r <= ST_FINISH;
              end
            end
            wfmd_pkg::FUNC_TRIP: begin
              state_r <= ST_FINISH;
              if (ch_ok) begin
                vcnt_r[idx] <= '0;
                rcnt_r[idx] <= '0;
                active_r    <= active_r | ch_bit;
                history_r   <= history_r | ch_bit;
              end
            end
            wfmd_pkg::FUNC_CLR_ALL: begin
              state_r   <= ST_FINISH;
              active_r  <= '0;
              history_r <= '0;
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                vcnt_r[i] <= '0;
                rcnt_r[i] <= '0;
              end
            end
            wfmd_pkg::FUNC_CLR_HIST: begin
              state_r   <= ST_FINISH;
              history_r <= '0;
            end
            wfmd_pkg::FUNC_CONFIG: begin
              state_r <= ST_FINISH;
              if (ch_ok) begin
                en_r[idx]   <= item_r.edge_enable;
                vcnt_r[idx] <= '0;
                rcnt_r[idx] <= '0;
              end
            end
            default: begin
              state_r <= ST_FINISH;
            end
          endcase
        end
        ST_CMP_HI: begin
          viol_r  <= ((wen_r & wfmd_pkg::EDGE_UPPER) != 2'd0) && cmp_gt;
          state_r <= ST_CMP_LO;
        end
        ST_CMP_LO: begin
          viol_r <= viol_nxt;
          if (viol_nxt) begin
            rcnt_r[idx] <= '0;
            cnt_r       <= vcnt_r[idx];
            lim_r       <= det_r[idx];
            state_r     <= ST_CNT_LT;
          end else if ((active_r & ch_bit) != '0) begin
            cnt_r   <= rcnt_r[idx];
            lim_r   <= rec_r[idx];
            state_r <= ST_CNT_LT;
          end else begin
            vcnt_r[idx] <= '0;
            state_r     <= ST_FINISH;
          end
        end
        ST_CNT_LT: begin
          // Count only while below the limit.
          if (cmp_gt) begin
            cnt_r <= cnt_r + 1'b1;
          end
          state_r <= ST_CNT_GE;
        end
        ST_CNT_GE: begin
          if (viol_r) begin
            vcnt_r[idx] <= cnt_r;
            if (!cmp_gt) begin
              active_r  <= active_r | ch_bit;
              history_r <= history_r | ch_bit;
            end
          end else begin
            rcnt_r[idx] <= cnt_r;
            if (!cmp_gt) begin
              active_r    <= active_r & ~ch_bit;
              vcnt_r[idx] <= '0;
            end
          end
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r              <= 1'b1;
            out_data_r.active_faults <= active_r;
            out_data_r.fault_history <= history_r;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a previous one is still in work");

  a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CNT_GE) |-> (cnt_r <= lim_r))
    else $error("debounce count ran past its limit");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result presented outside the finish step");
`endif

endmodule

`default_nettype wire
